/* hdl/spq_pkg.sv */
package spq_pkg;

   localparam int CMD_BITS   = 2;
   localparam int FIELD_BITS = 16;
   localparam int CAP_BITS   = 5;
   localparam int COUNT_BITS = 5;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_PEEK   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_type;

endpackage

/* hdl/spq_req_if.sv */
interface spq_req_if;
   import spq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   cmd;
   logic [FIELD_BITS-1:0] item_key;
   logic [FIELD_BITS-1:0] item_tag;

   modport source (output valid, output cmd, output item_key, output item_tag, input ready);
   modport sink (input valid, input cmd, input item_key, input item_tag, output ready);
endinterface

/* hdl/spq_rsp_if.sv */
interface spq_rsp_if;
   import spq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [FIELD_BITS-1:0] out_key;
   logic [FIELD_BITS-1:0] out_tag;
   logic [COUNT_BITS-1:0] item_count;

   modport source (output valid, output status, output out_key, output out_tag,
                   output item_count, input ready);
   modport sink (input valid, input status, input out_key, input out_tag,
                 input item_count, output ready);
endinterface

/* hdl/spq_ctrl.sv */
module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spq_pkg::ctrl_type ctrl
);
   import spq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            // hold until the result register can take the outcome
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctrl      = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         S_EXEC: begin
            ctrl.exec = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.exec) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/spq_datapath.sv */
module spq_datapath #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16,
   parameter int TAG_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [spq_pkg::CAP_BITS-1:0]   csr_wr_data,
   input  spq_pkg::ctrl_type              ctrl,
   input  logic [spq_pkg::CMD_BITS-1:0]   req_cmd,
   input  logic [spq_pkg::FIELD_BITS-1:0] req_item_key,
   input  logic [spq_pkg::FIELD_BITS-1:0] req_item_tag,
   output logic [1:0]                     rsp_status,
   output logic [spq_pkg::FIELD_BITS-1:0] rsp_out_key,
   output logic [spq_pkg::FIELD_BITS-1:0] rsp_out_tag,
   output logic [spq_pkg::COUNT_BITS-1:0] rsp_item_count
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > CAP_BITS) ? CW : CAP_BITS;

   // request register
   cmd_type             cmd_ff;
   logic [KEY_BITS-1:0] new_key_ff;
   logic [TAG_BITS-1:0] new_tag_ff;

   logic [CAP_BITS-1:0] cap_ff;
   logic [CW-1:0]       count_ff, count_in;

   // one cell per entry, front at index 0
   logic [KEY_BITS-1:0] key_ff [DEPTH];
   logic [KEY_BITS-1:0] key_in [DEPTH];
   logic [TAG_BITS-1:0] tag_ff [DEPTH];
   logic [TAG_BITS-1:0] tag_in [DEPTH];

   logic [DEPTH-1:0] less;
   logic [DEPTH-1:0] less_prev;
   logic             full;
   logic             empty;

   status_type            status_in;
   logic [FIELD_BITS-1:0] out_key_in;
   logic [FIELD_BITS-1:0] out_tag_in;

   logic [1:0]            status_ff;
   logic [FIELD_BITS-1:0] out_key_ff;
   logic [FIELD_BITS-1:0] out_tag_ff;
   logic [COUNT_BITS-1:0] item_count_ff;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         less[i] = (CW'(i) < count_ff) && (key_ff[i] < new_key_ff);
      end
   end

   assign less_prev = {less[DEPTH-2:0], 1'b0};
   assign full      = (LW'(count_ff) >= LW'(cap_ff)) || (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      count_in   = count_ff;
      status_in  = ST_OK;
      out_key_in = '0;
      out_tag_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         key_in[i] = key_ff[i];
         tag_in[i] = tag_ff[i];
      end
      case (cmd_ff)
         CMD_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               // move smaller keys back, drop the new request after its equals
               for (int i = 0; i < DEPTH; i++) begin
                  if (less_prev[i]) begin
                     key_in[i] = key_ff[(i == 0) ? 0 : i - 1];
                     tag_in[i] = tag_ff[(i == 0) ? 0 : i - 1];
                  end else if (less[i] || (CW'(i) == count_ff)) begin
                     key_in[i] = new_key_ff;
                     tag_in[i] = new_tag_ff;
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end
         CMD_REMOVE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               out_key_in = FIELD_BITS'(key_ff[0]);
               out_tag_in = FIELD_BITS'(tag_ff[0]);
               // advance every entry one place to the front
               for (int i = 0; i < DEPTH - 1; i++) begin
                  key_in[i] = key_ff[i + 1];
                  tag_in[i] = tag_ff[i + 1];
               end
               count_in = count_ff - CW'(1);
            end
         end
         CMD_PEEK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               out_key_in = FIELD_BITS'(key_ff[0]);
               out_tag_in = FIELD_BITS'(tag_ff[0]);
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         if (ctrl.exec) count_ff <= count_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff     <= cmd_type'(req_cmd);
         new_key_ff <= KEY_BITS'(req_item_key);
         new_tag_ff <= TAG_BITS'(req_item_tag);
      end
      if (ctrl.exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            key_ff[i] <= key_in[i];
            tag_ff[i] <= tag_in[i];
         end
         status_ff     <= status_in;
         out_key_ff    <= out_key_in;
         out_tag_ff    <= out_tag_in;
         item_count_ff <= COUNT_BITS'(LW'(count_in));
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_out_key    = out_key_ff;
   assign rsp_out_tag    = out_tag_ff;
   assign rsp_item_count = item_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("held count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.exec && cmd_ff == CMD_INSERT && !full |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted insert did not grow the count");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.exec && cmd_ff == CMD_REMOVE && !empty |=> count_ff == $past(count_ff) - CW'(1))
      else $error("remove did not shrink the count");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(2) |-> key_ff[0] >= key_ff[1])
      else $error("front entries out of order");

endmodule

/* hdl/sorted_priority_queue.sv */
// An accepted request is loaded into the request register; the controller then
// waits in its execute state until the result register is free; the insert or
// remove shifts every entry at that point. No new request is taken in between.
// A new request is accepted while the previous result still waits to be taken.
// Reset (synchronous, active high) empties the queue and sets the capacity to 16;
// entry contents stay undefined until written.
module sorted_priority_queue #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16,
   parameter int TAG_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [spq_pkg::CAP_BITS-1:0] csr_wr_data,
   spq_req_if.sink                      req_bus,
   spq_rsp_if.source                    rsp_bus
);
   import spq_pkg::*;

   ctrl_type ctrl;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctrl      (ctrl)
   );

   spq_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .ctrl           (ctrl),
      .req_cmd        (req_bus.cmd),
      .req_item_key   (req_bus.item_key),
      .req_item_tag   (req_bus.item_tag),
      .rsp_status     (rsp_bus.status),
      .rsp_out_key    (rsp_bus.out_key),
      .rsp_out_tag    (rsp_bus.out_tag),
      .rsp_item_count (rsp_bus.item_count)
   );

endmodule

/* bench/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int                  Q_DEPTH    = 16;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam logic [CAP_BITS-1:0] CAP_ZERO   = 5'd0;
   localparam logic [CAP_BITS-1:0] CAP_ONE    = 5'd1;
   localparam logic [CAP_BITS-1:0] CAP_MAX    = 5'd31;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   typedef struct packed {
      status_type            status;
      logic [FIELD_BITS-1:0] key;
      logic [FIELD_BITS-1:0] tag;
      logic [COUNT_BITS-1:0] count;
   } queue_result_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CAP_BITS-1:0] csr_wr_data;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // mirror of the queue contents, front first
   logic [FIELD_BITS-1:0] held_key [Q_DEPTH];
   logic [FIELD_BITS-1:0] held_tag [Q_DEPTH];
   int                    held_n    = 0;
   int                    cap_limit = CAP_RESET;

   queue_result_type pending_results [$];
   int               error_count     = 0;
   int               gap_max         = 17;
   int               stall_max       = 17;
   int               hold_off_cycles = 0;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic queue_result_type apply_request(logic [CMD_BITS-1:0] cmd,
                                                      logic [FIELD_BITS-1:0] key,
                                                      logic [FIELD_BITS-1:0] tag);
      queue_result_type r;
      int               pos;
      int               lim;
      r.status = ST_OK;
      r.key    = '0;
      r.tag    = '0;
      lim = (cap_limit > Q_DEPTH) ? Q_DEPTH : cap_limit;
      case (cmd)
         CMD_INSERT: begin
            if (held_n >= lim) begin
               r.status = ST_FULL;
            end else begin
               // place after every entry with an equal or higher key
               pos = held_n;
               while (pos > 0 && held_key[pos-1] < key) begin
                  held_key[pos] = held_key[pos-1];
                  held_tag[pos] = held_tag[pos-1];
                  pos--;
               end
               held_key[pos] = key;
               held_tag[pos] = tag;
               held_n++;
            end
         end
         CMD_REMOVE, CMD_PEEK: begin
            if (held_n == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.key = held_key[0];
               r.tag = held_tag[0];
               if (cmd == CMD_REMOVE) begin
                  for (int i = 0; i + 1 < held_n; i++) begin
                     held_key[i] = held_key[i+1];
                     held_tag[i] = held_tag[i+1];
                  end
                  held_n--;
               end
            end
         end
         default: ;
      endcase
      r.count = held_n[COUNT_BITS-1:0];
      return r;
   endfunction

   task automatic send_request(input logic [CMD_BITS-1:0] cmd,
                               input logic [FIELD_BITS-1:0] key,
                               input logic [FIELD_BITS-1:0] tag);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= cmd;
      req_bus.item_key <= key;
      req_bus.item_tag <= tag;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(apply_request(cmd, key, tag));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_BITS-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_limit = value;
   endtask

   function automatic logic [FIELD_BITS-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return FIELD_BITS'($urandom_range(0, 7));  // crowd equal keys
         default: return FIELD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [CMD_BITS-1:0] pick_cmd(mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return CMD_UNUSED;
      case (mix)
         MIX_FILL:  return (roll < 70) ? CMD_INSERT : (roll < 85) ? CMD_REMOVE : CMD_PEEK;
         MIX_DRAIN: return (roll < 30) ? CMD_INSERT : (roll < 85) ? CMD_REMOVE : CMD_PEEK;
         default:   return (roll < 45) ? CMD_INSERT : (roll < 80) ? CMD_REMOVE : CMD_PEEK;
      endcase
   endfunction

   function automatic logic [CAP_BITS-1:0] pick_capacity();
      case ($urandom_range(0, 7))
         0:       return CAP_ZERO;
         1:       return CAP_ONE;
         2:       return CAP_RESET;
         3:       return CAP_MAX;
         default: return CAP_BITS'($urandom_range(0, 31));
      endcase
   endfunction

   // result side: random stalls, with a long hold-off on request
   initial begin
      int stall;
      queue_result_type exp_r;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = $urandom_range(0, stall_max);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (pending_results.size() == 0) begin
            $display("%0t: result with no request pending: status %0d key %0h tag %0h count %0d",
                     $realtime, rsp_bus.status, rsp_bus.out_key, rsp_bus.out_tag,
                     rsp_bus.item_count);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_bus.status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status,
                        rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.out_key !== exp_r.key) begin
               $display("%0t: out_key expected %0h actual %0h", $realtime, exp_r.key,
                        rsp_bus.out_key);
               error_count++;
            end
            if (rsp_bus.out_tag !== exp_r.tag) begin
               $display("%0t: out_tag expected %0h actual %0h", $realtime, exp_r.tag,
                        rsp_bus.out_tag);
               error_count++;
            end
            if (rsp_bus.item_count !== exp_r.count) begin
               $display("%0t: item_count expected %0d actual %0d", $realtime, exp_r.count,
                        rsp_bus.item_count);
               error_count++;
            end
         end
      end
   end

   task automatic test_order_and_empty();
      send_request(CMD_PEEK, '0, '0);
      send_request(CMD_REMOVE, '1, '1);
      send_request(CMD_UNUSED, '1, '1);
      send_request(CMD_INSERT, 16'h0000, 16'hFFFF);
      send_request(CMD_INSERT, 16'hFFFF, 16'h0000);
      // equal keys must leave in arrival order
      send_request(CMD_INSERT, 16'h8000, 16'h0001);
      send_request(CMD_INSERT, 16'h8000, 16'h0002);
      send_request(CMD_INSERT, 16'h8000, 16'h0003);
      send_request(CMD_PEEK, '0, '0);
      send_request(CMD_UNUSED, 16'h1234, 16'h5678);
      repeat (6) send_request(CMD_REMOVE, '0, '0);
   endtask

   task automatic test_capacity_limits();
      set_capacity(CAP_ZERO);
      send_request(CMD_INSERT, 16'h0010, 16'hAAAA);
      set_capacity(CAP_ONE);
      send_request(CMD_INSERT, 16'h0010, 16'hAAAA);
      send_request(CMD_INSERT, 16'h0020, 16'h5555);
      set_capacity(5'd3);
      send_request(CMD_INSERT, 16'h0020, 16'h5555);
      send_request(CMD_INSERT, 16'h0005, 16'h0F0F);
      // lower the limit below the count: held items stay, inserts refused
      set_capacity(CAP_ONE);
      send_request(CMD_INSERT, 16'h7FFF, 16'hF0F0);
      send_request(CMD_REMOVE, '0, '0);
      send_request(CMD_REMOVE, '0, '0);
      send_request(CMD_INSERT, 16'h7FFF, 16'hF0F0);
      send_request(CMD_REMOVE, '0, '0);
      send_request(CMD_INSERT, 16'h7FFF, 16'hF0F0);
   endtask

   task automatic test_backpressure();
      set_capacity(CAP_RESET);
      gap_max = 0;
      hold_off_cycles = 300;
      repeat (40) begin
         send_request(($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_INSERT, pick_key(),
                      FIELD_BITS'($urandom));
      end
      wait_idle();
      gap_max = 17;
   endtask

   task automatic test_random_traffic();
      int      sent;
      int      len;
      mix_type mix;
      sent = 0;
      while (sent < 1300) begin
         set_capacity(pick_capacity());
         case ($urandom_range(0, 2))
            0:       mix = MIX_FILL;
            1:       mix = MIX_DRAIN;
            default: mix = MIX_EVEN;
         endcase
         gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 17;
         stall_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
         len = $urandom_range(20, 80);
         repeat (len) begin
            send_request(pick_cmd(mix), pick_key(), FIELD_BITS'($urandom));
            sent++;
         end
      end
      gap_max   = 17;
      stall_max = 17;
   endtask

   initial begin
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.cmd      <= CMD_INSERT;
      req_bus.item_key <= '0;
      req_bus.item_tag <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_order_and_empty();
      test_capacity_limits();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
